// ----- rtl/core/tdd_pkg.sv -----
`timescale 1ns / 1ps

package tdd_pkg;

    // Number of identifiers the set can hold.
    localparam int SET_CAPACITY = 64;

    // Width of the entry counter (it must reach SET_CAPACITY itself).
    localparam int CNT_W = $clog2(SET_CAPACITY + 1);
    // Width of an index into the identifier store.
    localparam int IDX_W = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;

    localparam int ID_W      = 128;
    localparam int DIGIT_W   = 6;
    localparam logic [DIGIT_W-1:0] ID_DIGITS = DIGIT_W'(32);

    localparam int BYTE_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int HELD_W     = 7;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_LOW_A = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LOW_F = 8'h66;
    localparam logic [BYTE_W-1:0] CH_TERM  = 8'h00;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED     = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SCAN,
        B_RESULT
    } t_back_state;

    // One finished identifier as handed from the parser to the set logic.
    typedef struct packed {
        logic            ok;
        logic [ID_W-1:0] value;
    } t_id_entry;

    // Handshake between queue and its neighbours.
    typedef struct packed {
        logic push;
        logic pop;
    } t_q_req;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] nib;
    } t_hex_digit;

    function automatic t_hex_digit hex_decode(input logic [BYTE_W-1:0] b);
        t_hex_digit r;
        r.is_hex = 1'b0;
        r.nib    = 4'd0;
        if (b inside {[CH_ZERO:CH_NINE]}) begin
            r.is_hex = 1'b1;
            r.nib    = b[3:0];
        end else if (b inside {[CH_LOW_A:CH_LOW_F]}) begin
            r.is_hex = 1'b1;
            r.nib    = 4'(b[3:0] + 4'd9);
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/tdd_front.sv -----
`timescale 1ns / 1ps

module tdd_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [tdd_pkg::BYTE_W-1:0] i_id_byte,
    input  tdd_pkg::t_q_stat           i_q_stat,
    output logic                       o_push,
    output tdd_pkg::t_id_entry         o_entry
);

    logic [tdd_pkg::DIGIT_W-1:0] r_digit_count, n_digit_count;
    logic                        r_digits_ok, n_digits_ok;
    logic [tdd_pkg::ID_W-1:0]    r_pending, n_pending;
    tdd_pkg::t_hex_digit         w_hex;
    logic                        w_accept;

    assign o_ready  = !i_q_stat.full;
    assign w_accept = i_valid && o_ready;
    assign w_hex    = tdd_pkg::hex_decode(i_id_byte);

    assign o_push         = w_accept && (i_id_byte == tdd_pkg::CH_TERM);
    assign o_entry.ok     = r_digits_ok && (r_digit_count == tdd_pkg::ID_DIGITS);
    assign o_entry.value  = r_pending;

    always_comb begin
        n_digit_count = r_digit_count;
        n_digits_ok   = r_digits_ok;
        n_pending     = r_pending;
        if (w_accept) begin
            if (i_id_byte == tdd_pkg::CH_TERM) begin
                n_digit_count = '0;
                n_digits_ok   = 1'b1;
                n_pending     = '0;
            end else if (!w_hex.is_hex || r_digit_count >= tdd_pkg::ID_DIGITS) begin
                // A bad character or a digit beyond the 32nd spoils the identifier.
                n_digits_ok = 1'b0;
            end else begin
                n_pending     = {r_pending[tdd_pkg::ID_W-5:0], w_hex.nib};
                n_digit_count = r_digit_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_count <= '0;
            r_digits_ok   <= 1'b1;
            r_pending     <= '0;
        end else begin
            r_digit_count <= n_digit_count;
            r_digits_ok   <= n_digits_ok;
            r_pending     <= n_pending;
        end
    end

endmodule

// ----- rtl/core/tdd_queue.sv -----
`timescale 1ns / 1ps

module tdd_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tdd_pkg::t_q_req    i_req,
    input  tdd_pkg::t_id_entry i_entry,
    output tdd_pkg::t_q_stat   o_stat,
    output tdd_pkg::t_id_entry o_head
);

    tdd_pkg::t_id_entry          r_slot [tdd_pkg::QUEUE_DEPTH];
    logic [tdd_pkg::QPTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [tdd_pkg::QCNT_W-1:0]  r_fill;
    logic                        w_push, w_pop;

    assign o_stat.full  = (r_fill == tdd_pkg::QCNT_W'(tdd_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_fill == '0);
    assign o_head       = r_slot[r_rd_ptr];

    assign w_push = i_req.push && !o_stat.full;
    assign w_pop  = i_req.pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (w_pop && !w_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/core/tdd_back.sv -----
`timescale 1ns / 1ps

module tdd_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tdd_pkg::t_q_stat             i_q_stat,
    input  tdd_pkg::t_id_entry           i_head,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [tdd_pkg::STATUS_W-1:0] o_status,
    output logic [tdd_pkg::HELD_W-1:0]   o_entries_held
);

    logic [tdd_pkg::ID_W-1:0] r_mem [tdd_pkg::SET_CAPACITY];

    tdd_pkg::t_back_state      r_state, n_state;
    logic [tdd_pkg::CNT_W-1:0] r_count, n_count;
    logic [tdd_pkg::CNT_W-1:0] r_idx, n_idx;
    logic                      r_rd_vld, n_rd_vld;
    tdd_pkg::t_status          r_status, n_status;
    logic [tdd_pkg::ID_W-1:0]  r_value, n_value;
    logic [tdd_pkg::ID_W-1:0]  r_rdata;
    logic                      w_rd_en, w_wr_en;
    logic                      w_hit;

    logic                      r_out_valid, n_out_valid;
    tdd_pkg::t_status          r_out_status, n_out_status;
    logic [tdd_pkg::HELD_W-1:0] r_out_held, n_out_held;

    assign w_hit = r_rd_vld && (r_rdata == r_value);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_rd_vld     = 1'b0;
        n_status     = r_status;
        n_value      = r_value;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_status = r_out_status;
        n_out_held   = r_out_held;
        o_pop        = 1'b0;
        w_rd_en      = 1'b0;
        w_wr_en      = 1'b0;
        case (r_state)
            tdd_pkg::B_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop   = 1'b1;
                    n_value = i_head.value;
                    n_idx   = '0;
                    if (i_head.ok) begin
                        n_state = tdd_pkg::B_SCAN;
                    end else begin
                        n_status = tdd_pkg::ST_MALFORMED;
                        n_state  = tdd_pkg::B_RESULT;
                    end
                end
            end
            tdd_pkg::B_SCAN: begin
                if (w_hit) begin
                    n_status = tdd_pkg::ST_DUPLICATE;
                    n_state  = tdd_pkg::B_RESULT;
                end else if (r_idx < r_count) begin
                    w_rd_en  = 1'b1;
                    n_rd_vld = 1'b1;
                    n_idx    = r_idx + 1'b1;
                end else if (r_count >= tdd_pkg::CNT_W'(tdd_pkg::SET_CAPACITY)) begin
                    n_status = tdd_pkg::ST_FULL;
                    n_state  = tdd_pkg::B_RESULT;
                end else begin
                    w_wr_en  = 1'b1;
                    n_count  = r_count + 1'b1;
                    n_status = tdd_pkg::ST_ADDED;
                    n_state  = tdd_pkg::B_RESULT;
                end
            end
            tdd_pkg::B_RESULT: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_held   = tdd_pkg::HELD_W'(r_count);
                    n_state      = tdd_pkg::B_IDLE;
                end
            end
            default: begin
                n_state = tdd_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rdata <= r_mem[r_idx[tdd_pkg::IDX_W-1:0]];
        end
        if (w_wr_en) begin
            r_mem[r_count[tdd_pkg::IDX_W-1:0]] <= r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tdd_pkg::B_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status     <= n_status;
        r_value      <= n_value;
        r_out_status <= n_out_status;
        r_out_held   <= n_out_held;
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_entries_held = r_out_held;

endmodule

// ----- rtl/core/transaction_id_dedup_set.sv -----
`timescale 1ns / 1ps

// Duplicate identifier filter over a set of 128-bit identifiers.
//
// Input channel (i_valid / o_ready / i_id_byte): one character per item. A
// run of 32 lowercase hex digits followed by a zero byte forms an identifier;
// the zero byte ends it and causes exactly one result, other bytes none.
// Output channel (o_valid / i_ready / o_status / o_entries_held): per
// identifier a status (added, malformed, duplicate, set full) and the number
// of identifiers held once it has been handled.
//
// The parser takes one byte a cycle while its two-entry queue has room. The set
// logic reads the store one entry a cycle through a registered read port, so a
// well-formed identifier waits there on a scan of up to the stored count of
// entries, while a malformed one skips the scan. When identifiers arrive faster
// than the set logic handles them, the queue fills and the input stalls.
//
// Reset empties the set and clears the parser; no clearing pass is needed,
// since only entries below the count are ever read. When the receiver stalls,
// the result waits in the output register, the set logic holds its next
// result, and once the queue fills the input channel drops o_ready.

module transaction_id_dedup_set (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [tdd_pkg::BYTE_W-1:0]   i_id_byte,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [tdd_pkg::STATUS_W-1:0] o_status,
    output logic [tdd_pkg::HELD_W-1:0]   o_entries_held
);

    tdd_pkg::t_q_stat   w_q_stat;
    tdd_pkg::t_q_req    w_q_req;
    tdd_pkg::t_id_entry w_push_entry;
    tdd_pkg::t_id_entry w_head;
    logic               w_push;
    logic               w_pop;

    assign w_q_req.push = w_push;
    assign w_q_req.pop  = w_pop;

    // Byte intake: hex decoding, digit counting and assembly of the value.
    tdd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_id_byte (i_id_byte),
        .i_q_stat  (w_q_stat),
        .o_push    (w_push),
        .o_entry   (w_push_entry)
    );

    // Finished identifiers wait here so that intake and lookup stall apart.
    tdd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_q_req),
        .i_entry (w_push_entry),
        .o_stat  (w_q_stat),
        .o_head  (w_head)
    );

    // Lookup, append and the output register.
    tdd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_stat       (w_q_stat),
        .i_head         (w_head),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_entries_held (o_entries_held)
    );

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the duplicate identifier filter.
//
// Bytes go in one per item, and a zero byte closes an identifier. The bench keeps
// its own tracker of the parser and the set. That tracker holds the digit count,
// the clean flag, the 128-bit value being built and the stored identifiers. The
// tracker runs at the moment each byte is accepted. Each zero byte queues one
// expected verdict: a status and the entry count. Every result that the block
// hands out is compared field by field with the oldest verdict still waiting.
module tb;
    import tdd_pkg::*;

    localparam int MAX_GAP      = 18;
    localparam int DRAIN_CYCLES = 200;
    localparam int RANDOM_BYTES = 700;
    localparam int LONG_HOLD    = 400;

    typedef struct {
        t_status           status;
        logic [HELD_W-1:0] held;
    } t_id_verdict;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_valid        = 1'b0;
    logic                o_ready;
    logic [BYTE_W-1:0]   i_id_byte      = '0;
    logic                o_valid;
    logic                i_ready        = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [HELD_W-1:0]   o_entries_held;

    // This is the bench's own view of the block. It holds the identifier being
    // parsed and the set that has been built so far.
    int              digits_seen  = 0;
    bit              digits_clean = 1'b1;
    logic [ID_W-1:0] pending_id   = '0;
    logic [ID_W-1:0] known_ids[$];

    t_id_verdict awaited_verdicts[$];
    t_id_verdict head_verdict;

    int error_count = 0;
    int bytes_sent  = 0;
    int verdict_tally[4];

    // Both sides read gaps_on. When it is low, neither side idles, and that gives
    // stretches of back-to-back traffic. The stall test sets long_hold_cycles.
    // The result side clears it once it has taken the value.
    bit gaps_on          = 1'b1;
    int long_hold_cycles = 0;

    transaction_id_dedup_set dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_id_byte      (i_id_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_entries_held (o_entries_held)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
        return (nib < 4'd10) ? CH_ZERO + 8'(nib) : CH_LOW_A + 8'(nib - 4'd10);
    endfunction

    function automatic logic [ID_W-1:0] random_id();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // This function moves the tracker on by one accepted byte. A nonzero byte
    // either shifts a digit in or spoils the identifier. A zero byte settles the
    // identifier and queues the verdict that the block must give for it.
    function automatic void absorb_id_byte(input logic [BYTE_W-1:0] b);
        logic [3:0]  nib;
        bit          is_digit;
        bit          found;
        t_id_verdict verdict;
        is_digit = 1'b1;
        nib      = 4'd0;
        if (b >= CH_ZERO && b <= CH_NINE) begin
            nib = 4'(b - CH_ZERO);
        end else if (b >= CH_LOW_A && b <= CH_LOW_F) begin
            nib = 4'(b - CH_LOW_A + 8'd10);
        end else begin
            is_digit = 1'b0;
        end
        if (b != CH_TERM) begin
            // A digit beyond the thirty-second spoils the identifier as a bad
            // character does. Neither of the two is shifted in.
            if (!is_digit || digits_seen >= ID_DIGITS) begin
                digits_clean = 1'b0;
            end else begin
                pending_id  = {pending_id[ID_W-5:0], nib};
                digits_seen = digits_seen + 1;
            end
        end else begin
            if (!digits_clean || digits_seen != ID_DIGITS) begin
                verdict.status = ST_MALFORMED;
            end else begin
                // The duplicate search comes first, so a stored identifier is
                // still reported as a duplicate once the set is full.
                found = 1'b0;
                foreach (known_ids[k]) begin
                    if (known_ids[k] == pending_id) found = 1'b1;
                end
                if (found) begin
                    verdict.status = ST_DUPLICATE;
                end else if (known_ids.size() >= SET_CAPACITY) begin
                    verdict.status = ST_FULL;
                end else begin
                    known_ids.push_back(pending_id);
                    verdict.status = ST_ADDED;
                end
            end
            verdict.held = HELD_W'(known_ids.size());
            awaited_verdicts.push_back(verdict);
            digits_seen  = 0;
            digits_clean = 1'b1;
            pending_id   = '0;
        end
    endfunction

    // This task offers one byte, after a random gap while gaps_on is set, and holds
    // it until the block takes it. The tracker moves on only at the edge that accepts the byte.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_id_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        absorb_id_byte(b);
        bytes_sent = bytes_sent + 1;
    endtask

    task automatic send_identifier(input logic [ID_W-1:0] id_value);
        for (int i = ID_W / 4 - 1; i >= 0; i--) begin
            send_byte(hex_char(id_value[i*4 +: 4]));
        end
        send_byte(CH_TERM);
    endtask

    // This task sends a run of digits of any length, then the terminator. A bad
    // character can go in at a random place, and that spoils the identifier.
    task automatic send_broken_identifier(input int digit_total, input bit with_bad);
        int                bad_at;
        logic [BYTE_W-1:0] bad_byte;
        bad_at = $urandom_range(0, digit_total);
        do begin
            bad_byte = BYTE_W'($urandom_range(1, 255));
        end while ((bad_byte >= CH_ZERO && bad_byte <= CH_NINE)
                   || (bad_byte >= CH_LOW_A && bad_byte <= CH_LOW_F));
        for (int i = 0; i <= digit_total; i++) begin
            if (with_bad && i == bad_at) send_byte(bad_byte);
            if (i < digit_total) send_byte(hex_char(4'($urandom)));
        end
        send_byte(CH_TERM);
    endtask

    // This task drops valid, lets every queued verdict come back, and then idles
    // for long enough that a stray extra result would still be caught.
    task automatic wait_for_verdicts();
        i_valid <= 1'b0;
        while (awaited_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // This test covers an empty identifier and one that is too short.
    task automatic test_short_identifiers();
        send_byte(CH_TERM);
        send_byte(hex_char(4'h1));
        send_byte(hex_char(4'ha));
        send_byte(CH_TERM);
        wait_for_verdicts();
    endtask

    // This test checks the bytes just outside each digit range, and bytes with
    // the top bit set. It also sends a full set of 32 digits that has one bad
    // character among them.
    task automatic test_bad_characters();
        logic [BYTE_W-1:0] bad_bytes[10];
        bad_bytes = '{CH_ZERO - 8'd1, CH_NINE + 8'd1, CH_LOW_A - 8'd1,
                      CH_LOW_F + 8'd1, 8'h41, 8'h46, 8'hff, 8'h80, 8'h01, 8'h7f};
        send_byte(hex_char(4'h5));
        foreach (bad_bytes[i]) send_byte(bad_bytes[i]);
        send_byte(CH_TERM);
        for (int i = 0; i < 16; i++) send_byte(hex_char(4'(i)));
        send_byte(8'h47);
        for (int i = 0; i < 16; i++) send_byte(hex_char(4'(15 - i)));
        send_byte(CH_TERM);
        wait_for_verdicts();
    endtask

    // This test adds two identifiers: one that uses every digit from '0' to
    // 'f', and one made of 'f' alone. It then sends the second one again.
    task automatic test_well_formed_and_duplicate();
        send_identifier(128'h0123456789abcdef_fedcba9876543210);
        send_identifier('1);
        send_identifier('1);
        wait_for_verdicts();
    endtask

    // This test sends thirty-three zero digits. The extra digit spoils the
    // identifier even though the first thirty-two form a valid value.
    task automatic test_too_many_digits();
        for (int i = 0; i < 33; i++) send_byte(CH_ZERO);
        send_byte(CH_TERM);
        wait_for_verdicts();
    endtask

    // Most of this traffic is well-formed identifiers, both new ones and repeats
    // of stored ones, so that it reaches the search and the append. The rest is
    // broken digit runs and raw noise.
    task automatic test_random_traffic();
        int stop_at;
        int pick;
        stop_at = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < stop_at) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            pick    = $urandom_range(0, 99);
            if (pick < 60 || (pick < 75 && known_ids.size() == 0)) begin
                send_identifier(random_id());
            end else if (pick < 75) begin
                send_identifier(known_ids[$urandom_range(0, known_ids.size() - 1)]);
            end else if (pick < 87) begin
                send_broken_identifier($urandom_range(0, 40), $urandom_range(0, 1));
            end else begin
                repeat ($urandom_range(0, 12)) send_byte(BYTE_W'($urandom_range(1, 255)));
                send_byte(CH_TERM);
            end
        end
        gaps_on = 1'b1;
        wait_for_verdicts();
    endtask

    // In this test the result side holds off for a long stretch, and the input
    // side keeps sending without gaps. The internal queue and the output register
    // fill up, so o_ready has to drop until the results drain.
    task automatic test_input_stall();
        gaps_on          = 1'b0;
        long_hold_cycles = LONG_HOLD;
        repeat (10) send_byte(CH_TERM);
        send_identifier(random_id());
        send_identifier(random_id());
        wait_for_verdicts();
        gaps_on = 1'b1;
    endtask

    task automatic test_fill_to_capacity();
        while (known_ids.size() < SET_CAPACITY) begin
            gaps_on = ($urandom_range(0, 2) != 0);
            send_identifier(random_id());
        end
        gaps_on = 1'b1;
        wait_for_verdicts();
    endtask

    // The set is full by now. A new identifier is refused. A stored one is still
    // reported as a duplicate, the first and the last entries included. A bad
    // identifier leaves the count at capacity.
    task automatic test_full_set();
        send_identifier(known_ids[0]);
        send_identifier(known_ids[SET_CAPACITY - 1]);
        send_identifier(random_id());
        repeat (10) begin
            case ($urandom_range(0, 2))
                0: send_identifier(random_id());
                1: send_identifier(known_ids[$urandom_range(0, SET_CAPACITY - 1)]);
                default: send_broken_identifier($urandom_range(0, 40), 1'b1);
            endcase
        end
        wait_for_verdicts();
    endtask

    // This process is the result side. Before each result it draws how long to
    // hold i_ready low. A long hold that a test has asked for replaces the drawn
    // one, and this process counts it out itself.
    initial begin : result_sink
        int hold;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold_cycles > 0) begin
                hold             = long_hold_cycles;
                long_hold_cycles = 0;
            end else begin
                hold = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (hold > 0) begin
                i_ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // This block checks each result that is accepted against the oldest verdict
    // still waiting.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (awaited_verdicts.size() == 0) begin
                error_count = error_count + 1;
                $display("%0t: unexpected result, expected none, actual status %0d entries %0d",
                         $time, o_status, o_entries_held);
            end else begin
                head_verdict = awaited_verdicts.pop_front();
                verdict_tally[head_verdict.status] = verdict_tally[head_verdict.status] + 1;
                if (o_status !== head_verdict.status) begin
                    error_count = error_count + 1;
                    $display("%0t: status mismatch, expected %0d (%s), actual %0d",
                             $time, head_verdict.status, head_verdict.status.name(), o_status);
                end
                if (o_entries_held !== head_verdict.held) begin
                    error_count = error_count + 1;
                    $display("%0t: entries_held mismatch, expected %0d, actual %0d",
                             $time, head_verdict.held, o_entries_held);
                end
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_short_identifiers();
        test_bad_characters();
        test_well_formed_and_duplicate();
        test_too_many_digits();
        test_random_traffic();
        test_input_stall();
        test_fill_to_capacity();
        test_full_set();

        $display("Verdicts checked: %0d added, %0d malformed, %0d duplicate, %0d refused as full.",
                 verdict_tally[ST_ADDED], verdict_tally[ST_MALFORMED],
                 verdict_tally[ST_DUPLICATE], verdict_tally[ST_FULL]);
        $display("%0d bytes sent; the set ended with %0d of %0d entries filled.",
                 bytes_sent, known_ids.size(), SET_CAPACITY);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // The limit is several times the slowest correct run: every byte waiting out
    // the longest gap, and every result waiting out a full scan and the longest
    // stall.
    initial begin
        #5_000_000;
        $display("Timeout with %0d verdicts still waiting.", awaited_verdicts.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
